// ===== rtl/bfmh_pkg.sv =====
`timescale 1ns / 1ps
package bfmh_pkg;

   localparam int FILTER_BITS = 4096;
   localparam int SEED_COUNT  = 4;
   localparam int CAND_COUNT  = 3 * SEED_COUNT;
   localparam int WORD_COUNT  = FILTER_BITS / 32;
   localparam int WADDR_W     = $clog2(WORD_COUNT);
   localparam int BIT_W       = $clog2(FILTER_BITS);
   localparam int MOD_W       = 13;
   localparam int HC_W        = 4;
   localparam int SEED_W      = $clog2(SEED_COUNT);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_3     = 3'd5;

   localparam logic [31:0] MM2     = 32'h5bd1e995;
   localparam logic [31:0] MM3_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MM3_C2  = 32'h1b873593;
   localparam logic [31:0] MM3_ADD = 32'he6546b64;
   localparam logic [31:0] FMIX_1  = 32'h85ebca6b;
   localparam logic [31:0] FMIX_2  = 32'hc2b2ae35;
   localparam logic [31:0] JK_INIT = 32'hdeadbeef;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  key_byte;
      logic [15:0] key_length;
      logic        last;
   } req_type;

   typedef struct packed {
      logic present;
      logic was_query;
   } rsp_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
      logic [63:0] d;
      d = {x, x} << r;
      return d[63:32];
   endfunction

endpackage

// ===== rtl/bfmh_rem_unit.sv =====
`timescale 1ns / 1ps
module bfmh_rem_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 dividend,
   input  logic [bfmh_pkg::MOD_W-1:0]  divisor,
   output logic                        done,
   output logic [bfmh_pkg::BIT_W-1:0]  remainder
);
   import bfmh_pkg::*;

   logic [BIT_W-1:0] rem_ff, rem_in;
   logic [31:0]      dvd_ff;
   logic [4:0]       cnt_ff;
   logic             run_ff, done_ff;
   logic [MOD_W-1:0] trial;

   // restoring remainder, one dividend bit a cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[31]};
      if (trial >= divisor) begin
         rem_in = BIT_W'(trial - divisor);
      end else begin
         rem_in = BIT_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            dvd_ff <= dividend;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[30:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/bloom_filter_multi_hash.sv =====
`timescale 1ns / 1ps
// channel   ports                               handshake
// request   start, busy, req_data               word taken when start & !busy
// response  rsp_strobe, rsp_data                one cycle per finished key, no stall
// csr       csr_we, csr_index, csr_wdata        written when csr_we
//
// every 4th key byte adds murmur steps on the shared multiplier, and every 12th
// byte adds lookup3 mixing when more bytes follow.
// the final word pads the missing bytes with zeros, then each candidate runs
// through the remainder unit and a filter ram read.
// after reset all 128 words of the filter ram are cleared with busy high.
// results cannot be held off: rsp_strobe lasts exactly one cycle.
module bloom_filter_multi_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bfmh_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output bfmh_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [bfmh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfmh_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bfmh_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_PAD, ST_W1, ST_W2, ST_W3, ST_W4, ST_WSEED,
      ST_XLOAD, ST_XSTEP, ST_FK1, ST_FK2, ST_CSEL, ST_M2A, ST_M2B, ST_M2C,
      ST_M3A, ST_M3B, ST_M3C, ST_L3A, ST_L3F, ST_MODGO, ST_MODWAIT,
      ST_BITRD, ST_BITOP, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [MOD_W-1:0]  bit_count_ff;
   logic [HC_W-1:0]   hash_count_ff;
   logic [31:0]       seed_ff [SEED_COUNT];
   logic [31:0]       m2_ff [SEED_COUNT];
   logic [31:0]       m3_ff [SEED_COUNT];
   logic [31:0]       la_ff [SEED_COUNT];
   logic [31:0]       lb_ff [SEED_COUNT];
   logic [31:0]       lc_ff [SEED_COUNT];
   logic [95:0]       blk_ff;
   logic [15:0]       bytes_seen_ff, key_len_ff;
   logic [3:0]        pos_ff;
   logic [1:0]        widx_ff;
   logic              key_open_ff, fin_pend_ff, mix_pend_ff, query_ff, hit_ff;
   logic [31:0]       h_ff, k2_ff, k3_ff, ja_ff, jb_ff, jc_ff;
   logic [2:0]        step_ff;
   logic [SEED_W-1:0] s_ff;
   logic [1:0]        fam_ff;
   logic [HC_W-1:0]   ci_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_data_ff;
   logic [WADDR_W-1:0] clr_ff;

   logic [31:0]        mem [WORD_COUNT];
   logic [31:0]        mem_rd_ff;
   logic               mem_we;
   logic [WADDR_W-1:0] mem_addr;
   logic [31:0]        mem_wdata;

   logic              accept;
   logic [7:0]        feed_byte;
   logic [15:0]       feed_len, bs_in;
   logic              feed_go, word_done, mix_in;
   logic [3:0]        pos_in;
   logic [1:0]        word_sel;
   logic [31:0]       blk_word, kt, x3;
   logic [1:0]        tail;
   logic [3:0]        rcount;
   logic [95:0]       tail_blk;
   logic [MOD_W-1:0]  eff_mod;
   logic [HC_W-1:0]   used;
   logic [31:0]       mul_a, mul_b, mul_p;
   logic [31:0]       hm, m3_in;
   logic [31:0]       mxa_in, mxb_in, mxc_in, fna_in, fnb_in, fnc_in;
   logic              rem_done;
   logic [BIT_W-1:0]  rem_val;
   logic              post_pad;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // byte feed, shared by real bytes and zero padding
   always_comb begin
      feed_byte = (state_ff == ST_IDLE) ? req_data.key_byte : 8'h00;
      feed_len  = (state_ff == ST_IDLE && !key_open_ff) ? req_data.key_length : key_len_ff;
      feed_go   = (bytes_seen_ff < feed_len);
      bs_in     = bytes_seen_ff + 16'd1;
      word_done = (bs_in[1:0] == 2'b00);
      mix_in    = (pos_ff == 4'd11) && (bs_in < feed_len);
      pos_in    = (pos_ff == 4'd11) ? 4'd0 : pos_ff + 4'd1;
   end

   always_comb begin
      word_sel = (state_ff == ST_W1 || state_ff == ST_W3) ? widx_ff : pos_ff[3:2];
      blk_word = blk_ff[{word_sel, 5'b00000} +: 32];
      tail     = key_len_ff[1:0];
      case (tail)
         2'd1:    kt = {24'h0, blk_word[7:0]};
         2'd2:    kt = {16'h0, blk_word[15:0]};
         2'd3:    kt = {8'h0, blk_word[23:0]};
         default: kt = 32'h0;
      endcase
      rcount = (pos_ff == 4'd0) ? 4'd12 : pos_ff;
      for (int i = 0; i < 12; i++) begin
         tail_blk[i*8 +: 8] = (4'(i) < rcount) ? blk_ff[i*8 +: 8] : 8'h00;
      end
      if (bit_count_ff == '0) begin
         eff_mod = MOD_W'(1);
      end else if (bit_count_ff > MOD_W'(FILTER_BITS)) begin
         eff_mod = MOD_W'(FILTER_BITS);
      end else begin
         eff_mod = bit_count_ff;
      end
      if (hash_count_ff == '0 || hash_count_ff > HC_W'(CAND_COUNT)) begin
         used = HC_W'(CAND_COUNT);
      end else begin
         used = hash_count_ff;
      end
      x3 = m3_ff[s_ff] ^ ((tail != 2'd0) ? k3_ff : 32'h0) ^ {16'h0, key_len_ff};
      hm    = rotl(m3_ff[s_ff] ^ k3_ff, 5'd13);
      m3_in = (hm << 2) + hm + MM3_ADD;
      post_pad = fin_pend_ff;
   end

   // the one shared multiplier
   always_comb begin
      mul_a = 32'h0;
      mul_b = 32'h0;
      case (state_ff)
         ST_W1:    begin mul_a = blk_word;              mul_b = MM2;    end
         ST_W2:    begin mul_a = h_ff ^ (h_ff >> 24);   mul_b = MM2;    end
         ST_W3:    begin mul_a = blk_word;              mul_b = MM3_C1; end
         ST_W4:    begin mul_a = rotl(h_ff, 5'd15);     mul_b = MM3_C2; end
         ST_WSEED: begin mul_a = m2_ff[s_ff];           mul_b = MM2;    end
         ST_FK1:   begin mul_a = kt;                    mul_b = MM3_C1; end
         ST_FK2:   begin mul_a = rotl(h_ff, 5'd15);     mul_b = MM3_C2; end
         ST_M2A:   begin mul_a = m2_ff[s_ff] ^ kt;      mul_b = MM2;    end
         ST_M2B:   begin mul_a = h_ff ^ (h_ff >> 13);   mul_b = MM2;    end
         ST_M3A:   begin mul_a = x3 ^ (x3 >> 16);       mul_b = FMIX_1; end
         ST_M3B:   begin mul_a = h_ff ^ (h_ff >> 13);   mul_b = FMIX_2; end
         default:  begin mul_a = 32'h0;                 mul_b = 32'h0;  end
      endcase
      mul_p = 32'(mul_a * mul_b);
   end

   // one lookup3 mix line and one final line per cycle
   always_comb begin
      mxa_in = ja_ff;
      mxb_in = jb_ff;
      mxc_in = jc_ff;
      case (step_ff)
         3'd0: begin mxa_in = (ja_ff - jc_ff) ^ rotl(jc_ff, 5'd4);  mxc_in = jc_ff + jb_ff; end
         3'd1: begin mxb_in = (jb_ff - ja_ff) ^ rotl(ja_ff, 5'd6);  mxa_in = ja_ff + jc_ff; end
         3'd2: begin mxc_in = (jc_ff - jb_ff) ^ rotl(jb_ff, 5'd8);  mxb_in = jb_ff + ja_ff; end
         3'd3: begin mxa_in = (ja_ff - jc_ff) ^ rotl(jc_ff, 5'd16); mxc_in = jc_ff + jb_ff; end
         3'd4: begin mxb_in = (jb_ff - ja_ff) ^ rotl(ja_ff, 5'd19); mxa_in = ja_ff + jc_ff; end
         3'd5: begin mxc_in = (jc_ff - jb_ff) ^ rotl(jb_ff, 5'd4);  mxb_in = jb_ff + ja_ff; end
         default: begin mxa_in = ja_ff; end
      endcase
      fna_in = ja_ff;
      fnb_in = jb_ff;
      fnc_in = jc_ff;
      case (step_ff)
         3'd0: fnc_in = (jc_ff ^ jb_ff) - rotl(jb_ff, 5'd14);
         3'd1: fna_in = (ja_ff ^ jc_ff) - rotl(jc_ff, 5'd11);
         3'd2: fnb_in = (jb_ff ^ ja_ff) - rotl(ja_ff, 5'd25);
         3'd3: fnc_in = (jc_ff ^ jb_ff) - rotl(jb_ff, 5'd16);
         3'd4: fna_in = (ja_ff ^ jc_ff) - rotl(jc_ff, 5'd4);
         3'd5: fnb_in = (jb_ff ^ ja_ff) - rotl(ja_ff, 5'd14);
         3'd6: fnc_in = (jc_ff ^ jb_ff) - rotl(jb_ff, 5'd24);
         default: fna_in = ja_ff;
      endcase
   end

   bfmh_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_MODGO),
      .dividend  (h_ff),
      .divisor   (eff_mod),
      .done      (rem_done),
      .remainder (rem_val)
   );

   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_BITOP && !query_ff);
      mem_addr  = (state_ff == ST_CLEAR) ? clr_ff : bit_ff[BIT_W-1:5];
      mem_wdata = (state_ff == ST_CLEAR) ? 32'h0 : (mem_rd_ff | (32'h1 << bit_ff[4:0]));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         bit_count_ff  <= MOD_W'(4096);
         hash_count_ff <= HC_W'(3);
         for (int i = 0; i < SEED_COUNT; i++) begin
            seed_ff[i] <= 32'(i);
         end
         bytes_seen_ff <= '0;
         pos_ff        <= '0;
         key_open_ff   <= 1'b0;
         fin_pend_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_BIT_COUNT:  bit_count_ff  <= csr_wdata[MOD_W-1:0];
               CSR_HASH_COUNT: hash_count_ff <= csr_wdata[HC_W-1:0];
               CSR_SEED_0:     seed_ff[0]    <= csr_wdata;
               CSR_SEED_1:     seed_ff[1]    <= csr_wdata;
               CSR_SEED_2:     seed_ff[2]    <= csr_wdata;
               CSR_SEED_3:     seed_ff[3]    <= csr_wdata;
               default:        ;
            endcase
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + WADDR_W'(1);
               if (clr_ff == WADDR_W'(WORD_COUNT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (!key_open_ff) begin
                     key_len_ff  <= req_data.key_length;
                     key_open_ff <= 1'b1;
                     for (int i = 0; i < SEED_COUNT; i++) begin
                        m2_ff[i] <= seed_ff[i] ^ {16'h0, req_data.key_length};
                        m3_ff[i] <= seed_ff[i];
                        la_ff[i] <= JK_INIT + {16'h0, req_data.key_length} + seed_ff[i];
                        lb_ff[i] <= JK_INIT + {16'h0, req_data.key_length} + seed_ff[i];
                        lc_ff[i] <= JK_INIT + {16'h0, req_data.key_length} + seed_ff[i];
                     end
                  end
                  query_ff    <= req_data.cmd;
                  fin_pend_ff <= req_data.last;
                  if (feed_go) begin
                     blk_ff[{pos_ff, 3'b000} +: 8] <= feed_byte;
                     bytes_seen_ff <= bs_in;
                     pos_ff        <= pos_in;
                     widx_ff       <= pos_ff[3:2];
                     mix_pend_ff   <= mix_in;
                  end
                  if (feed_go && word_done) begin
                     state_ff <= ST_W1;
                  end else if (req_data.last) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               if (feed_go) begin
                  blk_ff[{pos_ff, 3'b000} +: 8] <= feed_byte;
                  bytes_seen_ff <= bs_in;
                  pos_ff        <= pos_in;
                  widx_ff       <= pos_ff[3:2];
                  mix_pend_ff   <= mix_in;
                  if (word_done) begin
                     state_ff <= ST_W1;
                  end
               end else begin
                  state_ff <= ST_FK1;
               end
            end
            ST_W1: begin h_ff  <= mul_p; state_ff <= ST_W2; end
            ST_W2: begin k2_ff <= mul_p; state_ff <= ST_W3; end
            ST_W3: begin h_ff  <= mul_p; state_ff <= ST_W4; end
            ST_W4: begin
               k3_ff    <= mul_p;
               s_ff     <= '0;
               state_ff <= ST_WSEED;
            end
            ST_WSEED: begin
               m2_ff[s_ff] <= mul_p ^ k2_ff;
               m3_ff[s_ff] <= m3_in;
               if (s_ff == SEED_W'(SEED_COUNT - 1)) begin
                  s_ff <= '0;
                  if (mix_pend_ff) begin
                     state_ff <= ST_XLOAD;
                  end else begin
                     state_ff <= post_pad ? ST_PAD : ST_IDLE;
                  end
               end else begin
                  s_ff <= s_ff + SEED_W'(1);
               end
            end
            ST_XLOAD: begin
               ja_ff    <= la_ff[s_ff] + blk_ff[31:0];
               jb_ff    <= lb_ff[s_ff] + blk_ff[63:32];
               jc_ff    <= lc_ff[s_ff] + blk_ff[95:64];
               step_ff  <= '0;
               state_ff <= ST_XSTEP;
            end
            ST_XSTEP: begin
               ja_ff <= mxa_in;
               jb_ff <= mxb_in;
               jc_ff <= mxc_in;
               if (step_ff == 3'd5) begin
                  la_ff[s_ff] <= mxa_in;
                  lb_ff[s_ff] <= mxb_in;
                  lc_ff[s_ff] <= mxc_in;
                  if (s_ff == SEED_W'(SEED_COUNT - 1)) begin
                     s_ff     <= '0;
                     state_ff <= post_pad ? ST_PAD : ST_IDLE;
                  end else begin
                     s_ff     <= s_ff + SEED_W'(1);
                     state_ff <= ST_XLOAD;
                  end
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            ST_FK1: begin h_ff <= mul_p; state_ff <= ST_FK2; end
            ST_FK2: begin
               k3_ff    <= mul_p;
               s_ff     <= '0;
               fam_ff   <= 2'd0;
               ci_ff    <= '0;
               hit_ff   <= 1'b1;
               state_ff <= ST_CSEL;
            end
            ST_CSEL: begin
               case (fam_ff)
                  2'd0:    state_ff <= ST_M2A;
                  2'd1:    state_ff <= ST_M3A;
                  default: state_ff <= ST_L3A;
               endcase
            end
            ST_M2A: begin
               h_ff     <= (tail != 2'd0) ? mul_p : m2_ff[s_ff];
               state_ff <= ST_M2B;
            end
            ST_M2B: begin h_ff <= mul_p; state_ff <= ST_M2C; end
            ST_M2C: begin h_ff <= h_ff ^ (h_ff >> 15); state_ff <= ST_MODGO; end
            ST_M3A: begin h_ff <= mul_p; state_ff <= ST_M3B; end
            ST_M3B: begin h_ff <= mul_p; state_ff <= ST_M3C; end
            ST_M3C: begin h_ff <= h_ff ^ (h_ff >> 16); state_ff <= ST_MODGO; end
            ST_L3A: begin
               if (key_len_ff == 16'h0) begin
                  h_ff     <= lc_ff[s_ff];
                  state_ff <= ST_MODGO;
               end else begin
                  ja_ff    <= la_ff[s_ff] + tail_blk[31:0];
                  jb_ff    <= lb_ff[s_ff] + tail_blk[63:32];
                  jc_ff    <= lc_ff[s_ff] + tail_blk[95:64];
                  step_ff  <= '0;
                  state_ff <= ST_L3F;
               end
            end
            ST_L3F: begin
               ja_ff <= fna_in;
               jb_ff <= fnb_in;
               jc_ff <= fnc_in;
               if (step_ff == 3'd6) begin
                  h_ff     <= fnc_in;
                  state_ff <= ST_MODGO;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            ST_MODGO: state_ff <= ST_MODWAIT;
            ST_MODWAIT: begin
               if (rem_done) begin
                  bit_ff   <= rem_val;
                  state_ff <= ST_BITRD;
               end
            end
            ST_BITRD: state_ff <= ST_BITOP;
            ST_BITOP: begin
               if (query_ff && !mem_rd_ff[bit_ff[4:0]]) begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_DONE;
               end else if (ci_ff == used - HC_W'(1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  ci_ff <= ci_ff + HC_W'(1);
                  if (s_ff == SEED_W'(SEED_COUNT - 1)) begin
                     s_ff   <= '0;
                     fam_ff <= fam_ff + 2'd1;
                  end else begin
                     s_ff <= s_ff + SEED_W'(1);
                  end
                  state_ff <= ST_CSEL;
               end
            end
            ST_DONE: begin
               rsp_strobe_ff         <= 1'b1;
               rsp_data_ff.present   <= query_ff & hit_ff;
               rsp_data_ff.was_query <= query_ff;
               key_open_ff           <= 1'b0;
               fin_pend_ff           <= 1'b0;
               bytes_seen_ff         <= '0;
               pos_ff                <= '0;
               state_ff              <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== rtl/bfmh_checker.sv =====
`timescale 1ns / 1ps
module bfmh_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bfmh_pkg::req_type req_data,
   input logic              rsp_strobe,
   input bfmh_pkg::rsp_type rsp_data
);

   // filter ram clear runs right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last) |=> busy)
      else $error("final word did not start the lookup");

   a_insert_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.was_query) |-> !rsp_data.present)
      else $error("insert reported present");

endmodule

bind bloom_filter_multi_hash bfmh_checker u_bfmh_checker (.*);
